### hdl/bspl_pkg.sv
`default_nettype none

package bspl_pkg;

    // width of a stored value, signed Q16.16
    localparam int VAL_W = 32;

    // iterations of the restoring divider, one quotient bit each
    localparam int DIV_STEPS = 32;

    // register reset values
    localparam logic [3:0] ORDER_RESET  = 4'd4;
    localparam logic [6:0] POINTS_RESET = 7'd4;
    localparam logic [2:0] COORDS_RESET = 3'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ORDER  = 2'd0;
    localparam logic [1:0] REG_POINTS = 2'd1;
    localparam logic [1:0] REG_COORDS = 2'd2;

    // input transaction kinds
    typedef enum logic [1:0] {
        OP_LOAD_KNOT = 2'd0,
        OP_LOAD_CTRL = 2'd1,
        OP_EVAL      = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E_LO,
        ST_E_HI,
        ST_E_CHK,
        ST_S_RD,
        ST_S_CMP,
        ST_C_RD,
        ST_C_WR,
        ST_T_A,
        ST_T_B,
        ST_T_D,
        ST_T_Z,
        ST_P_LO,
        ST_P_HI,
        ST_M1,
        ST_M2,
        ST_SUM,
        ST_DVI,
        ST_DV,
        ST_WB,
        ST_O_RD,
        ST_O_PUSH,
        ST_ERR
    } state_t;

    // datapath commands
    typedef struct packed {
        logic load;
        logic knot_rd;
        logic lat_lo;
        logic ctrl_rd;
        logic scr_copy;
        logic scr_rd;
        logic lat_a;
        logic lat_b;
        logic lat_plo;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_init;
        logic div_step;
        logic scr_res;
        logic push_res;
        logic push_err;
        logic last;
    } dp_cmd_t;

    // datapath status
    typedef struct packed {
        logic range_err;
        logic knot_le_u;
        logic den_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/bspline_curve_de_boor_eval_top.sv
`default_nettype none

// B-spline curve evaluator, de Boor scheme, signed Q16.16.
// Input stream: tuser carries the operation (load knot, load control
// component, evaluate); tdata carries slot, component, load value, parameter.
// Loads give no result. An evaluate transaction gives
// coord_count results (coordinate index in tuser, value in tdata, tlast on
// the final one), or a single out-of-range result with tuser bit 2 set.
// Evaluation work, with p = order and U = updates with a nonzero knot
// difference (at most p(p-1)/2), is dominated by the 32-step restoring
// divider, one quotient bit per cycle, running for each coordinate of each
// update. The block takes one item at a time.
// A finished result waits in the output register; while the receiver
// stalls the block holds its state and still accepts loads once idle.
// Reset (aresetn low, synchronous) restores order 4, 4 points, 3
// coordinates and empties the output register; tables are not cleared.
// Configuration writes take effect at once; the user must make them only while idle; the block does not enforce this.

module bspline_curve_de_boor_eval_top #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_ORDER  = 8,
    parameter int MAX_COORDS = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[6:0], component[8:7], load_value[40:9], param[72:41], zero fill
    input  wire  [79:0] s_axis_tdata,
    // operation[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // coord_value[31:0]
    output logic [31:0] m_axis_tdata,
    // coord_index[1:0], out_of_range[2]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [6:0]  cfg_data
);

    localparam int KAW = $clog2(MAX_POINTS + MAX_ORDER);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = $clog2(MAX_COORDS + 1);
    localparam int QW  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;

    bspl_pkg::dp_cmd_t    cmd;
    bspl_pkg::dp_status_t status;
    logic [KAW-1:0]       knot_addr;
    logic [PW-1:0]        pt_idx;
    logic [QW-1:0]        crd_idx;
    logic [OW-1:0]        ord_p;
    logic [NW-1:0]        pts_n;
    logic [CW-1:0]        crd_c;
    logic [1:0]           out_idx;
    logic signed [31:0]   out_val;
    logic                 out_oor;

    bspl_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_ORDER  (MAX_ORDER),
        .MAX_COORDS (MAX_COORDS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_op      (s_axis_tuser),
        .s_tready  (s_axis_tready),
        .ord_p     (ord_p),
        .pts_n     (pts_n),
        .crd_c     (crd_c),
        .status    (status),
        .cmd       (cmd),
        .knot_addr (knot_addr),
        .pt_idx    (pt_idx),
        .crd_idx   (crd_idx)
    );

    bspl_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_ORDER  (MAX_ORDER),
        .MAX_COORDS (MAX_COORDS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_op           (s_axis_tuser),
        .s_slot         (s_axis_tdata[6:0]),
        .s_comp         (s_axis_tdata[8:7]),
        .s_load_value   (s_axis_tdata[40:9]),
        .s_param        (s_axis_tdata[72:41]),
        .cmd            (cmd),
        .knot_addr      (knot_addr),
        .pt_idx         (pt_idx),
        .crd_idx        (crd_idx),
        .status         (status),
        .ord_p          (ord_p),
        .pts_n          (pts_n),
        .crd_c          (crd_c),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_coord_index  (out_idx),
        .m_coord_value  (out_val),
        .m_out_of_range (out_oor),
        .m_last         (m_axis_tlast)
    );

    // result packing
    always_comb begin
        m_axis_tdata = out_val;
        m_axis_tuser = {out_oor, out_idx};
    end

endmodule

`default_nettype wire

### hdl/bspl_ctrl.sv
`default_nettype none

module bspl_ctrl #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_ORDER  = 8,
    parameter int MAX_COORDS = 4
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_tvalid,
    input  wire  [1:0]               s_op,
    output logic                     s_tready,
    input  wire  [$clog2(MAX_ORDER+1)-1:0]  ord_p,
    input  wire  [$clog2(MAX_POINTS+1)-1:0] pts_n,
    input  wire  [$clog2(MAX_COORDS+1)-1:0] crd_c,
    input  bspl_pkg::dp_status_t     status,
    output bspl_pkg::dp_cmd_t        cmd,
    output logic [$clog2(MAX_POINTS+MAX_ORDER)-1:0] knot_addr,
    output logic [$clog2(MAX_POINTS)-1:0]           pt_idx,
    output logic [((MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1)-1:0] crd_idx
);

    localparam int KAW = $clog2(MAX_POINTS + MAX_ORDER);
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int QW  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;

    bspl_pkg::state_t state_reg, state_next;
    logic [PW-1:0] i_reg, i_next;
    logic [PW-1:0] k_reg, k_next;
    logic [PW-1:0] j_reg, j_next;
    logic [OW-1:0] r_reg, r_next;
    logic [QW-1:0] q_reg, q_next;
    logic [4:0]    step_reg, step_next;

    logic          last_q;
    logic          j_more;
    logic          r_more;
    logic          tri_more;
    logic          copy_done;
    logic          scan_done;
    logic [PW-1:0] k_found;

    // loop conditions
    always_comb begin
        last_q    = int'(q_reg) == int'(crd_c) - 1;
        j_more    = int'(j_reg) + int'(r_reg) > int'(k_reg) + 2;
        r_more    = int'(r_reg) > 2;
        tri_more  = j_more || r_more;
        copy_done = (j_reg == k_reg) && last_q;
        scan_done = int'(i_reg) == int'(pts_n) - 1;
        k_found   = status.knot_le_u ? i_reg : k_reg;
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bspl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        i_reg    <= i_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bspl_pkg::ST_IDLE:
                if (s_tvalid && bspl_pkg::op_t'(s_op) == bspl_pkg::OP_EVAL) begin
                    state_next = bspl_pkg::ST_E_LO;
                end
            bspl_pkg::ST_E_LO:  state_next = bspl_pkg::ST_E_HI;
            bspl_pkg::ST_E_HI:  state_next = bspl_pkg::ST_E_CHK;
            bspl_pkg::ST_E_CHK:
                state_next = status.range_err ? bspl_pkg::ST_ERR : bspl_pkg::ST_S_RD;
            bspl_pkg::ST_S_RD:  state_next = bspl_pkg::ST_S_CMP;
            bspl_pkg::ST_S_CMP:
                state_next = scan_done ? bspl_pkg::ST_C_RD : bspl_pkg::ST_S_RD;
            bspl_pkg::ST_C_RD:  state_next = bspl_pkg::ST_C_WR;
            bspl_pkg::ST_C_WR: begin
                if (!copy_done) begin
                    state_next = bspl_pkg::ST_C_RD;
                end else if (int'(ord_p) >= 2) begin
                    state_next = bspl_pkg::ST_T_A;
                end else begin
                    state_next = bspl_pkg::ST_O_RD;
                end
            end
            bspl_pkg::ST_T_A:   state_next = bspl_pkg::ST_T_B;
            bspl_pkg::ST_T_B:   state_next = bspl_pkg::ST_T_D;
            bspl_pkg::ST_T_D:   state_next = bspl_pkg::ST_T_Z;
            bspl_pkg::ST_T_Z: begin
                if (!status.den_zero) begin
                    state_next = bspl_pkg::ST_P_LO;
                end else begin
                    state_next = tri_more ? bspl_pkg::ST_T_A : bspl_pkg::ST_O_RD;
                end
            end
            bspl_pkg::ST_P_LO:  state_next = bspl_pkg::ST_P_HI;
            bspl_pkg::ST_P_HI:  state_next = bspl_pkg::ST_M1;
            bspl_pkg::ST_M1:    state_next = bspl_pkg::ST_M2;
            bspl_pkg::ST_M2:    state_next = bspl_pkg::ST_SUM;
            bspl_pkg::ST_SUM:   state_next = bspl_pkg::ST_DVI;
            bspl_pkg::ST_DVI:   state_next = bspl_pkg::ST_DV;
            bspl_pkg::ST_DV:
                if (step_reg == 5'(bspl_pkg::DIV_STEPS - 1)) begin
                    state_next = bspl_pkg::ST_WB;
                end
            bspl_pkg::ST_WB: begin
                if (!last_q) begin
                    state_next = bspl_pkg::ST_P_LO;
                end else begin
                    state_next = tri_more ? bspl_pkg::ST_T_A : bspl_pkg::ST_O_RD;
                end
            end
            bspl_pkg::ST_O_RD:  state_next = bspl_pkg::ST_O_PUSH;
            bspl_pkg::ST_O_PUSH:
                if (status.out_free) begin
                    state_next = last_q ? bspl_pkg::ST_IDLE : bspl_pkg::ST_O_RD;
                end
            bspl_pkg::ST_ERR:
                if (status.out_free) begin
                    state_next = bspl_pkg::ST_IDLE;
                end
            default: state_next = bspl_pkg::ST_IDLE;
        endcase
    end

    // loop counters
    always_comb begin
        i_next    = i_reg;
        k_next    = k_reg;
        j_next    = j_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        step_next = step_reg;
        case (state_reg)
            bspl_pkg::ST_E_CHK: begin
                i_next = PW'(int'(ord_p) - 1);
                k_next = PW'(int'(ord_p) - 1);
            end
            bspl_pkg::ST_S_CMP: begin
                k_next = k_found;
                if (scan_done) begin
                    j_next = PW'(int'(k_found) - int'(ord_p) + 1);
                    q_next = '0;
                end else begin
                    i_next = i_reg + PW'(1);
                end
            end
            bspl_pkg::ST_C_WR: begin
                if (copy_done) begin
                    r_next = ord_p;
                    j_next = k_reg;
                    q_next = '0;
                end else if (last_q) begin
                    q_next = '0;
                    j_next = j_reg + PW'(1);
                end else begin
                    q_next = q_reg + QW'(1);
                end
            end
            bspl_pkg::ST_T_Z, bspl_pkg::ST_WB: begin
                if (state_reg == bspl_pkg::ST_WB && !last_q) begin
                    q_next = q_reg + QW'(1);
                end else if (state_reg == bspl_pkg::ST_WB || status.den_zero) begin
                    q_next = '0;
                    if (j_more) begin
                        j_next = j_reg - PW'(1);
                    end else if (r_more) begin
                        r_next = r_reg - OW'(1);
                        j_next = k_reg;
                    end
                end else begin
                    q_next = '0;
                end
            end
            bspl_pkg::ST_DVI: step_next = '0;
            bspl_pkg::ST_DV:  step_next = step_reg + 5'd1;
            bspl_pkg::ST_O_PUSH:
                if (status.out_free && !last_q) begin
                    q_next = q_reg + QW'(1);
                end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        knot_addr = '0;
        pt_idx    = j_reg;
        crd_idx   = q_reg;
        unique case (state_reg)
            bspl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bspl_pkg::ST_E_LO: begin
                cmd.knot_rd = 1'b1;
                knot_addr   = KAW'(int'(ord_p) - 1);
            end
            bspl_pkg::ST_E_HI: begin
                cmd.knot_rd = 1'b1;
                cmd.lat_lo  = 1'b1;
                knot_addr   = KAW'(pts_n);
            end
            bspl_pkg::ST_S_RD: begin
                cmd.knot_rd = 1'b1;
                knot_addr   = KAW'(i_reg);
            end
            bspl_pkg::ST_C_RD:  cmd.ctrl_rd  = 1'b1;
            bspl_pkg::ST_C_WR:  cmd.scr_copy = 1'b1;
            bspl_pkg::ST_T_A: begin
                cmd.knot_rd = 1'b1;
                knot_addr   = KAW'(int'(j_reg) + int'(r_reg) - 1);
            end
            bspl_pkg::ST_T_B: begin
                cmd.knot_rd = 1'b1;
                cmd.lat_a   = 1'b1;
                knot_addr   = KAW'(j_reg);
            end
            bspl_pkg::ST_T_D:   cmd.lat_b = 1'b1;
            bspl_pkg::ST_P_LO: begin
                cmd.scr_rd = 1'b1;
                pt_idx     = PW'(int'(j_reg) - 1);
            end
            bspl_pkg::ST_P_HI: begin
                cmd.scr_rd  = 1'b1;
                cmd.lat_plo = 1'b1;
            end
            bspl_pkg::ST_M1:    cmd.mul1     = 1'b1;
            bspl_pkg::ST_M2:    cmd.mul2     = 1'b1;
            bspl_pkg::ST_SUM:   cmd.sum      = 1'b1;
            bspl_pkg::ST_DVI:   cmd.div_init = 1'b1;
            bspl_pkg::ST_DV:    cmd.div_step = 1'b1;
            bspl_pkg::ST_WB:    cmd.scr_res  = 1'b1;
            bspl_pkg::ST_O_RD: begin
                cmd.scr_rd = 1'b1;
                pt_idx     = k_reg;
            end
            bspl_pkg::ST_O_PUSH: begin
                cmd.push_res = status.out_free;
                cmd.last     = last_q;
            end
            bspl_pkg::ST_ERR:   cmd.push_err = status.out_free;
            default: ;
        endcase
    end

`ifndef SYNTH
    // results are only pushed into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_res || cmd.push_err) |-> status.out_free)
        else $error("push into occupied output register");

    // an evaluation starts only from an accepted evaluate transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bspl_pkg::ST_E_LO) |->
        $past(s_tvalid && s_tready && s_op == 2'(bspl_pkg::OP_EVAL)))
        else $error("evaluation without accepted transaction");

    // write-back follows a full divider run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bspl_pkg::ST_WB) |->
        ($past(state_reg) == bspl_pkg::ST_DV && $past(step_reg) == 5'(bspl_pkg::DIV_STEPS - 1)))
        else $error("write-back before divider finished");

    // triangle steps keep the order at two or more and j within the span
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bspl_pkg::ST_T_A) |->
        (int'(r_reg) >= 2 && j_reg <= k_reg && int'(j_reg) + int'(r_reg) > int'(k_reg) + 1))
        else $error("triangle indices out of span");
`endif

endmodule

`default_nettype wire

### hdl/bspl_dp.sv
`default_nettype none

module bspl_dp #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_ORDER  = 8,
    parameter int MAX_COORDS = 4
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_we,
    input  wire  [1:0]               cfg_index,
    input  wire  [6:0]               cfg_data,
    input  wire  [1:0]               s_op,
    input  wire  [6:0]               s_slot,
    input  wire  [1:0]               s_comp,
    input  wire  signed [31:0]       s_load_value,
    input  wire  signed [31:0]       s_param,
    input  bspl_pkg::dp_cmd_t        cmd,
    input  wire  [$clog2(MAX_POINTS+MAX_ORDER)-1:0] knot_addr,
    input  wire  [$clog2(MAX_POINTS)-1:0]           pt_idx,
    input  wire  [((MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1)-1:0] crd_idx,
    output bspl_pkg::dp_status_t     status,
    output logic [$clog2(MAX_ORDER+1)-1:0]  ord_p,
    output logic [$clog2(MAX_POINTS+1)-1:0] pts_n,
    output logic [$clog2(MAX_COORDS+1)-1:0] crd_c,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [1:0]               m_coord_index,
    output logic signed [31:0]       m_coord_value,
    output logic                     m_out_of_range,
    output logic                     m_last
);

    localparam int KNOT_DEPTH  = MAX_POINTS + MAX_ORDER;
    localparam int STORE_DEPTH = MAX_POINTS * MAX_COORDS;
    localparam int KAW = $clog2(KNOT_DEPTH);
    localparam int SAW = $clog2(STORE_DEPTH);
    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int CW  = $clog2(MAX_COORDS + 1);

    logic [3:0] order_reg;
    logic [6:0] points_reg;
    logic [2:0] coords_reg;

    logic signed [31:0] knot_mem [KNOT_DEPTH];
    logic signed [31:0] ctrl_mem [STORE_DEPTH];
    logic signed [31:0] scr_mem  [STORE_DEPTH];

    logic signed [31:0] knot_q, ctrl_q, scr_q;
    logic signed [31:0] u_reg, a_reg, lo_reg, hi_reg;
    logic signed [32:0] da_reg, db_reg, den_reg;
    logic signed [63:0] prod1_reg, prod2_reg, num_reg;
    logic               lo_err_reg;
    logic               qneg_reg, ovf_reg;
    logic [32:0]        dmag_reg, rem_reg;
    logic [31:0]        lsh_reg, quo_reg;
    logic               out_valid_reg;

    logic [SAW-1:0]     st_addr, ld_addr;
    logic               ld_knot, ld_ctrl;
    logic signed [64:0] mres;
    logic signed [64:0] sum65;
    logic [63:0]        nmag;
    logic [32:0]        dmag;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic signed [31:0] div_res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg  <= bspl_pkg::ORDER_RESET;
            points_reg <= bspl_pkg::POINTS_RESET;
            coords_reg <= bspl_pkg::COORDS_RESET;
        end else if (cfg_we) begin
            if (cfg_index == bspl_pkg::REG_ORDER)  order_reg  <= cfg_data[3:0];
            if (cfg_index == bspl_pkg::REG_POINTS) points_reg <= cfg_data;
            if (cfg_index == bspl_pkg::REG_COORDS) coords_reg <= cfg_data[2:0];
        end
    end

    // clamped sizes
    always_comb begin
        ord_p = (order_reg == '0) ? OW'(1) :
                (int'(order_reg) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(order_reg);
        pts_n = (points_reg == '0) ? NW'(1) :
                (int'(points_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(points_reg);
        crd_c = (coords_reg == '0) ? CW'(1) :
                (int'(coords_reg) > MAX_COORDS) ? CW'(MAX_COORDS) : CW'(coords_reg);
    end

    // load decode and store addressing
    always_comb begin
        ld_knot = cmd.load && bspl_pkg::op_t'(s_op) == bspl_pkg::OP_LOAD_KNOT
                  && int'(s_slot) < KNOT_DEPTH;
        ld_ctrl = cmd.load && bspl_pkg::op_t'(s_op) == bspl_pkg::OP_LOAD_CTRL
                  && int'(s_slot) < MAX_POINTS && int'(s_comp) < MAX_COORDS;
        ld_addr = SAW'(int'(s_slot) * MAX_COORDS + int'(s_comp));
        st_addr = SAW'(int'(pt_idx) * MAX_COORDS + int'(crd_idx));
    end

    // knot table
    always_ff @(posedge aclk) begin
        if (ld_knot) knot_mem[KAW'(s_slot)] <= s_load_value;
        if (cmd.knot_rd) knot_q <= knot_mem[knot_addr];
    end

    // control store
    always_ff @(posedge aclk) begin
        if (ld_ctrl) ctrl_mem[ld_addr] <= s_load_value;
        if (cmd.ctrl_rd) ctrl_q <= ctrl_mem[st_addr];
    end

    // scratch points
    always_ff @(posedge aclk) begin
        if (cmd.scr_copy) begin
            scr_mem[st_addr] <= ctrl_q;
        end else if (cmd.scr_res) begin
            scr_mem[st_addr] <= div_res;
        end
        if (cmd.scr_rd) scr_q <= scr_mem[st_addr];
    end

    // shared multiplier, 33 by 32 bits, exact in 64 bits
    always_comb begin
        if (cmd.mul1) begin
            mres = da_reg * lo_reg;
        end else begin
            mres = db_reg * hi_reg;
        end
        sum65 = {prod1_reg[63], prod1_reg} + {prod2_reg[63], prod2_reg};
        nmag  = num_reg[63] ? (64'd0 - 64'(num_reg)) : 64'(num_reg);
        dmag  = den_reg[32] ? (33'd0 - 33'(den_reg)) : 33'(den_reg);
        rem_sh = {rem_reg, lsh_reg[31]};
        rem_ge = rem_sh >= {1'b0, dmag_reg};
    end

    // quotient saturation to 32 bits
    always_comb begin
        if (ovf_reg) begin
            div_res = qneg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (qneg_reg) begin
            div_res = (quo_reg > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - quo_reg);
        end else begin
            div_res = (quo_reg > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo_reg);
        end
    end

    // arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.load && bspl_pkg::op_t'(s_op) == bspl_pkg::OP_EVAL) u_reg <= s_param;
        if (cmd.lat_lo) lo_err_reg <= u_reg < knot_q;
        if (cmd.lat_a) a_reg <= knot_q;
        if (cmd.lat_b) begin
            den_reg <= 33'(a_reg) - 33'(knot_q);
            da_reg  <= 33'(a_reg) - 33'(u_reg);
            db_reg  <= 33'(u_reg) - 33'(knot_q);
        end
        if (cmd.lat_plo) lo_reg <= scr_q;
        if (cmd.mul1) begin
            hi_reg    <= scr_q;
            prod1_reg <= mres[63:0];
        end
        if (cmd.mul2) prod2_reg <= mres[63:0];
        if (cmd.sum) begin
            if (sum65[64] != sum65[63]) begin
                num_reg <= sum65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            end else begin
                num_reg <= sum65[63:0];
            end
        end
        if (cmd.div_init) begin
            qneg_reg <= num_reg[63] ^ den_reg[32];
            dmag_reg <= dmag;
            ovf_reg  <= {1'b0, nmag[63:32]} >= dmag;
            rem_reg  <= {1'b0, nmag[63:32]};
            lsh_reg  <= nmag[31:0];
            quo_reg  <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? 33'(rem_sh - {1'b0, dmag_reg}) : rem_sh[32:0];
            lsh_reg <= {lsh_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], rem_ge};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push_res || cmd.push_err) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.push_res) begin
            m_coord_index  <= 2'(crd_idx);
            m_coord_value  <= scr_q;
            m_out_of_range <= 1'b0;
            m_last         <= cmd.last;
        end else if (cmd.push_err) begin
            m_coord_index  <= '0;
            m_coord_value  <= '0;
            m_out_of_range <= 1'b1;
            m_last         <= 1'b1;
        end
    end

    // status
    always_comb begin
        m_tvalid         = out_valid_reg;
        status.out_free  = !out_valid_reg || m_tready;
        status.range_err = (int'(pts_n) < int'(ord_p)) || lo_err_reg || (u_reg > knot_q);
        status.knot_le_u = knot_q <= u_reg;
        status.den_zero  = den_reg == '0;
    end

endmodule

`default_nettype wire
